[rtl/block_bitmap_allocator_assert.svh]
// Assertion macros for the block bitmap allocator.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("bba assertion failed");

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("bba assertion failed");

`endif

[rtl/bba_pkg.sv]
// Shared constants and types for the block bitmap allocator.
// No dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int RESERVED_DEF   = 64;
  localparam int WORD_BITS_DEF  = 32;

  localparam int IDX_W  = 12;
  localparam int STAT_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

[rtl/bba_map_mem.sv]
// Used-block map storage: one write port, one read port, registered read data.
// Standalone; sized by the allocator top level.
module bba_map_mem #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 128,
  parameter int AW        = 7
) (
  input  logic                 clk,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

[rtl/bba_word_unit.sv]
// Per-word scan unit: lowest free bit search, set/clear of one bit and the
// reset pattern of a map word. Purely combinational; no package dependency.
module bba_word_unit #(
  parameter int WORD_BITS  = 32,
  parameter int NUM_BLOCKS = 4096,
  parameter int RESERVED   = 64,
  parameter int BW         = 13,
  parameter int CW         = 13,
  parameter int PW         = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [BW-1:0]        base_i,
  input  logic [PW-1:0]        free_pos_i,
  output logic                 found_o,
  output logic [PW-1:0]        pos_o,
  output logic [WORD_BITS-1:0] alloc_word_o,
  output logic [WORD_BITS-1:0] free_word_o,
  output logic [WORD_BITS-1:0] init_word_o
);

  logic [WORD_BITS-1:0] hot;

  // isolate the lowest clear bit
  assign hot     = ~word_i & (word_i + WORD_BITS'(1));
  assign found_o = ~&word_i;

  always_comb begin
    pos_o = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (hot[i]) begin
        pos_o = pos_o | PW'(i);
      end
    end
  end

  assign alloc_word_o = word_i | hot;
  assign free_word_o  = word_i & ~(WORD_BITS'(1) << free_pos_i);

  // blocks below RESERVED and padding past NUM_BLOCKS read as used
  always_comb begin
    logic [CW-1:0] blk;
    init_word_o = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      blk = CW'(base_i) + CW'(j);
      init_word_o[j] = (blk < CW'(RESERVED)) || (blk >= CW'(NUM_BLOCKS));
    end
  end

endmodule

[rtl/block_bitmap_allocator.sv]
// First-free block allocator over a used-block bitmap held in a WORD_BITS-wide
// single-port-read memory. After reset an initialisation pass writes the reset
// pattern into all NUM_WORDS map words (128 at defaults); in_ready stays low
// until it ends. An allocate request reads the map one word per cycle from
// word 0 up to the word holding the first free block; a full map costs the
// whole scan. A free request steps a word pointer to the target word, then does
// a read-modify-write; an index at or past NUM_BLOCKS returns ST_RANGE instead.
// One request is in flight at a time; the result sits in an output register,
// so the next request is taken while a result waits. Depends on bba_pkg,
// bba_map_mem, bba_word_unit.
`include "block_bitmap_allocator_assert.svh"

module block_bitmap_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF,
  parameter int RESERVED   = bba_pkg::RESERVED_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [bba_pkg::IDX_W-1:0]  in_block_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bba_pkg::IDX_W-1:0]  out_granted_index,
  output logic [bba_pkg::STAT_W-1:0] out_status
);

  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int CW        = (BW > bba_pkg::IDX_W) ? BW : bba_pkg::IDX_W;
  localparam int PW        = $clog2(WORD_BITS);

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_WALK = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic [BW-1:0]               base_r, base_nxt;
  logic                        cmd_r, cmd_nxt;
  logic [bba_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic [bba_pkg::IDX_W-1:0]   res_idx_r, res_idx_nxt;
  bba_pkg::status_t            res_stat_r, res_stat_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bba_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  bba_pkg::status_t            out_stat_r, out_stat_nxt;

  logic                        mem_we;
  logic [AW-1:0]               mem_raddr;
  logic [WORD_BITS-1:0]        mem_wdata;
  logic [WORD_BITS-1:0]        mem_rdata;
  logic                        found;
  logic [PW-1:0]               pos;
  logic [WORD_BITS-1:0]        alloc_word, free_word, init_word;
  logic [PW-1:0]               free_pos;
  logic [CW-1:0]               idx_ext, word_end, diff, gsum;
  logic                        last_word, in_fire, out_free;

  assign idx_ext   = CW'(idx_r);
  assign word_end  = CW'(base_r) + CW'(WORD_BITS);
  assign diff      = idx_ext - CW'(base_r);
  assign free_pos  = diff[PW-1:0];
  assign gsum      = CW'(base_r) + CW'(pos);
  assign last_word = (addr_r == AW'(NUM_WORDS - 1));
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  bba_map_mem #(
    .WORD_BITS(WORD_BITS),
    .NUM_WORDS(NUM_WORDS),
    .AW       (AW)
  ) u_mem (
    .clk    (clk),
    .we_i   (mem_we),
    .waddr_i(addr_r),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bba_word_unit #(
    .WORD_BITS (WORD_BITS),
    .NUM_BLOCKS(NUM_BLOCKS),
    .RESERVED  (RESERVED),
    .BW        (BW),
    .CW        (CW),
    .PW        (PW)
  ) u_word (
    .word_i      (mem_rdata),
    .base_i      (base_r),
    .free_pos_i  (free_pos),
    .found_o     (found),
    .pos_o       (pos),
    .alloc_word_o(alloc_word),
    .free_word_o (free_word),
    .init_word_o (init_word)
  );

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    base_nxt      = base_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    res_idx_nxt   = res_idx_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_stat_nxt  = out_stat_r;
    mem_we        = 1'b0;
    mem_wdata     = init_word;
    mem_raddr     = addr_r;

    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        if (last_word) begin
          addr_nxt  = '0;
          base_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + BW'(WORD_BITS);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt      = in_command;
          idx_nxt      = in_block_index;
          addr_nxt     = '0;
          base_nxt     = '0;
          res_idx_nxt  = '0;
          res_stat_nxt = bba_pkg::ST_OK;
          if (in_command == bba_pkg::CMD_FREE &&
              CW'(in_block_index) >= CW'(NUM_BLOCKS)) begin
            res_stat_nxt = bba_pkg::ST_RANGE;
            state_nxt    = S_DONE;
          end else if (in_command == bba_pkg::CMD_FREE) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_WALK: begin
        if (idx_ext < word_end) begin
          state_nxt = S_RD;
        end else begin
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + BW'(WORD_BITS);
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // prefetch the next word so the scan moves one word per cycle
        mem_raddr = last_word ? addr_r : addr_r + AW'(1);
        if (cmd_r == bba_pkg::CMD_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = free_word;
          state_nxt = S_DONE;
        end else if (found) begin
          mem_we      = 1'b1;
          mem_wdata   = alloc_word;
          res_idx_nxt = gsum[bba_pkg::IDX_W-1:0];
          state_nxt   = S_DONE;
        end else if (last_word) begin
          res_stat_nxt = bba_pkg::ST_FULL;
          state_nxt    = S_DONE;
        end else begin
          addr_nxt = addr_r + AW'(1);
          base_nxt = base_r + BW'(WORD_BITS);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_stat_nxt  = res_stat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      addr_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_stat_r <= res_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_index = out_idx_r;
  assign out_status        = out_stat_r;

  `BBA_ASSERT_NXT(a_accept_starts_work, in_fire, state_r != S_IDLE)
  `BBA_ASSERT_IMP(a_full_grants_zero, out_valid_r && out_stat_r == bba_pkg::ST_FULL,
                  out_idx_r == '0)
  `BBA_ASSERT_IMP(a_no_write_when_parked, state_r == S_IDLE || state_r == S_DONE,
                  !mem_we)

endmodule

[sim/tb.sv]
// Self-checking testbench for block_bitmap_allocator at its default size.
// A directed table, then random traffic with a pause to drain, checked against
// typed rows or a bitmap predictor. Depends on bba_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int NBLK      = bba_pkg::NUM_BLOCKS_DEF;
  localparam int NRSV      = bba_pkg::RESERVED_DEF;
  localparam int IDX_W     = bba_pkg::IDX_W;
  localparam int IDLE_MAX  = 2000;
  localparam int DRAIN_CYC = 200;

  typedef struct packed {
    logic [IDX_W-1:0]  granted;
    bba_pkg::status_t  status;
  } grant_t;

  typedef struct packed {
    logic   cmd;
    logic [IDX_W-1:0] idx;
    logic   typed;
    grant_t res;
  } dir_row_t;

  // typed rows carry a result readable at a glance; the rest use the predictor
  localparam int N_DIR = 23;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b1, '{12'd64, bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd4095, 1'b1, '{12'd65, bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd64,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b1, '{12'd64, bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd0,    1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd4095, 1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd4095, 1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd4095, 1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd2048, 1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd63,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd31,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd65,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd66,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd1,    1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd32,   1'b1, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_ALLOC, 12'd0,    1'b0, '{12'd0,  bba_pkg::ST_OK}},
    '{bba_pkg::CMD_FREE,  12'd4095, 1'b1, '{12'd0,  bba_pkg::ST_OK}}
  };

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_command;
  logic [IDX_W-1:0]           in_block_index;
  logic                       out_valid;
  logic                       out_ready;
  logic [IDX_W-1:0]           out_granted_index;
  logic [bba_pkg::STAT_W-1:0] out_status;

  bit     used_map [NBLK];
  int     hi_water;
  grant_t expected_grants [$];
  int     fail_cnt;
  int     sent_cnt;
  bit     quiet;
  int     idle_cnt;

  block_bitmap_allocator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_block_index    (in_block_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_index (out_granted_index),
    .out_status        (out_status)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // first-free allocate or free of one block on the predicted map
  task automatic apply_request(input logic cmd, input logic [IDX_W-1:0] idx,
                               output grant_t res);
    bit found;
    found = 1'b0;
    res.granted = '0;
    res.status  = bba_pkg::ST_OK;
    if (cmd == bba_pkg::CMD_ALLOC) begin
      for (int b = 0; b < NBLK && !found; b++) begin
        if (!used_map[b]) begin
          used_map[b] = 1'b1;
          res.granted = IDX_W'(b);
          if (b > hi_water) hi_water = b;
          found = 1'b1;
        end
      end
      if (!found) res.status = bba_pkg::ST_FULL;
    end else if (int'(idx) >= NBLK) begin
      res.status = bba_pkg::ST_RANGE;
    end else begin
      used_map[idx] = 1'b0;
    end
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 3))
      0: return IDX_W'($urandom_range(0, NBLK - 1));
      1: return IDX_W'($urandom_range(0, hi_water));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return IDX_W'(NRSV - 1 + $urandom_range(0, 1));
          default: return IDX_W'($urandom_range(0, 127) * 32 +
                                 ($urandom_range(0, 1) ? 31 : 0));
        endcase
      end
      default: return IDX_W'($urandom_range(0, hi_water + 1 < NBLK ?
                                               hi_water + 1 : NBLK - 1));
    endcase
  endfunction

  task automatic send_request(input logic cmd, input logic [IDX_W-1:0] idx,
                              input logic typed, input grant_t typed_res);
    int     gap;
    grant_t pred;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_block_index <= idx;
    do @(posedge clk); while (!in_ready);
    apply_request(cmd, idx, pred);
    expected_grants.push_back(typed ? typed_res : pred);
    sent_cnt++;
    quiet = ((sent_cnt / 256) % 4) == 2;
  endtask

  task automatic run_random(input int n, input int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_request(bba_pkg::CMD_ALLOC, IDX_W'($urandom), 1'b0, '0);
      else
        send_request(bba_pkg::CMD_FREE, pick_index(), 1'b0, '0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = bba_pkg::CMD_ALLOC;
    in_block_index = '0;
    out_ready      = 1'b0;
    fail_cnt       = 0;
    sent_cnt       = 0;
    quiet          = 1'b0;
    hi_water       = NRSV - 1;
    for (int b = 0; b < NBLK; b++) begin
      used_map[b] = (b < NRSV);
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIR; r++)
      send_request(DIR_ROWS[r].cmd, DIR_ROWS[r].idx, DIR_ROWS[r].typed,
                   DIR_ROWS[r].res);

    run_random(600, 55);

    // hold off until the block has answered every request
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);

    // allocation-heavy traffic pushes the scan deeper into the map
    run_random(677, 60);

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result side: random ready stalls, compare against oldest expectation
  initial begin
    int     stall;
    grant_t exp_res;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_grants.size() == 0) begin
        $error("unexpected result: granted_index %0d status %0d",
               out_granted_index, out_status);
        fail_cnt++;
      end else begin
        exp_res = expected_grants.pop_front();
        if (out_granted_index !== exp_res.granted) begin
          $error("granted_index: expected %0d, actual %0d", exp_res.granted,
                 out_granted_index);
          fail_cnt++;
        end
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, out_status);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt + 1 >= IDLE_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

endmodule
